>>> hw/rtl/budgeted_rate_task_scheduler_macros.svh
// Assertion helpers shared by the checks of the scheduler's checker.
`ifndef BUDGETED_RATE_TASK_SCHEDULER_MACROS_SVH
`define BUDGETED_RATE_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define BRTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define BRTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

>>> hw/rtl/brts_pkg.sv
package brts_pkg;

    // Task table depth and field widths
    localparam int NUM_TASKS   = 16;
    localparam int IDX_W       = 4;
    localparam int TICK_W      = 32;
    localparam int RATE_W      = 16;
    localparam int US_W        = 16;
    localparam int TAKEN_W     = 32;
    localparam int SPARE_W     = 32;
    localparam int SPARE_CNT_W = 5;
    localparam int CFG_W       = 16;
    localparam int IN_DATA_W   = 104;
    localparam int OUT_DATA_W  = 64;

    // Divider width and step counter width
    localparam int DIV_W       = 16;
    localparam int DIV_CNT_W   = $clog2(DIV_W);

    // Reset values of the registers
    localparam logic [CFG_W-1:0] LOOP_RATE_RST  = 16'd1000;
    localparam logic [CFG_W-1:0] PASS_BUDGET_RST = 16'd1000;

    // Pass count at which the spare accumulator is halved, and the count it restarts from
    localparam logic [SPARE_CNT_W-1:0] SPARE_LAST = SPARE_CNT_W'(31);
    localparam logic [SPARE_CNT_W-1:0] SPARE_HALF = SPARE_CNT_W'(16);

    // Register indexes
    localparam logic REG_LOOP_RATE   = 1'b0;
    localparam logic REG_PASS_BUDGET = 1'b1;

    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_CHECK  = 2'd1,
        FUNC_FINISH = 2'd2,
        FUNC_END    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EXEC
    } state_t;

endpackage

>>> hw/rtl/brts_div.sv
module brts_div
    import brts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     den_reg, den_next;
    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       trial;

    // Shift one dividend bit into the remainder and try a subtract
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        trial     = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial[DIV_W])
            begin
                rem_next = shifted[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath holds no reset
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/budgeted_rate_task_scheduler.sv
// Rate scheduler with a per-pass time budget. One result word per input word,
// one item in flight at a time. For a check item (func 1) the task interval
// loop_rate_hz / task_rate_hz comes from a restoring divider that resolves one
// quotient bit per cycle; the item is then evaluated into the output register.
// Start, finish and end items skip the divider. A finished result waits in
// the output register, and the next item is accepted while it waits. No
// clearing pass after reset.
module budgeted_rate_task_scheduler
    import brts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    // Input words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // task_index[3:0], tick_now[35:4], task_rate_hz[51:36], task_max_us[67:52],
    // time_taken_us[99:68], zero fill[103:100]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func[1:0]
    input  logic [1:0]            s_axis_tuser,
    // Result words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // run_task[0], slipped[1], overran[2], pass_over[3], time_left_us[19:4],
    // spare_us[51:20], spare_passes[56:52], zero fill[63:57]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]       loop_rate_reg;
    logic [CFG_W-1:0]       pass_budget_reg;

    logic [TICK_W-1:0]      last_run_tick_reg [NUM_TASKS];
    logic [US_W-1:0]        time_avail_reg, time_avail_next;
    logic [US_W-1:0]        allowed_reg, allowed_next;
    logic                   exhausted_reg, exhausted_next;
    logic [SPARE_W-1:0]     spare_reg, spare_next;
    logic [SPARE_CNT_W-1:0] spare_cnt_reg, spare_cnt_next;

    func_t                  func_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [TICK_W-1:0]      tick_reg;
    logic [US_W-1:0]        max_reg;
    logic [TAKEN_W-1:0]     taken_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    logic                   accept;
    logic                   div_start;
    logic                   div_done;
    logic [DIV_W-1:0]       quotient;
    logic [RATE_W-1:0]      in_rate;
    logic [RATE_W-1:0]      divisor;
    logic                   fire;
    logic                   idx_valid;
    logic                   stamp;

    logic [US_W-1:0]        dt;
    logic [DIV_W-1:0]       interval;
    logic                   run;
    logic                   slip;
    logic                   over;
    logic [SPARE_W-1:0]     spare_sum;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign in_rate = s_axis_tdata[51:36];
    // Zero rate counts as rate 1
    assign divisor = (in_rate == '0) ? RATE_W'(1) : in_rate;

    brts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (loop_rate_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Sequence: accept, divide for checks, evaluate into the output register
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        fire          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (func_t'(s_axis_tuser) == FUNC_CHECK)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    fire       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Evaluate the item against the scheduler state
    always_comb
    begin
        idx_valid       = ({1'b0, idx_reg} < (IDX_W + 1)'(NUM_TASKS));
        dt              = tick_reg[US_W-1:0] - last_run_tick_reg[idx_reg][US_W-1:0];
        interval        = (quotient == '0) ? DIV_W'(1) : quotient;
        run             = 1'b0;
        slip            = 1'b0;
        over            = 1'b0;
        stamp           = 1'b0;
        time_avail_next = time_avail_reg;
        allowed_next    = allowed_reg;
        exhausted_next  = exhausted_reg;
        spare_next      = spare_reg;
        spare_cnt_next  = spare_cnt_reg;
        spare_sum       = spare_reg + (exhausted_reg ? '0 : SPARE_W'(time_avail_reg));
        case (func_reg)
            FUNC_START:
            begin
                time_avail_next = pass_budget_reg;
                exhausted_next  = 1'b0;
            end
            FUNC_CHECK:
            begin
                if (idx_valid && (dt >= interval))
                begin
                    allowed_next = max_reg;
                    slip = ({1'b0, dt} >= {interval, 1'b0});
                    run  = (max_reg <= time_avail_reg) && !exhausted_reg;
                end
            end
            FUNC_FINISH:
            begin
                stamp = idx_valid;
                over  = (taken_reg > TAKEN_W'(allowed_reg));
                if (!exhausted_reg)
                begin
                    if (taken_reg >= TAKEN_W'(time_avail_reg))
                    begin
                        exhausted_next = 1'b1;
                    end
                    else
                    begin
                        time_avail_next = time_avail_reg - taken_reg[US_W-1:0];
                    end
                end
            end
            default:
            begin
                // End of pass: bank the spare time, halve when the pass count is 31 and restart it at 16
                if (spare_cnt_reg == SPARE_LAST)
                begin
                    spare_cnt_next = SPARE_HALF;
                    spare_next     = spare_sum >> 1;
                end
                else
                begin
                    spare_cnt_next = spare_cnt_reg + 1'b1;
                    spare_next     = spare_sum;
                end
            end
        endcase
        out_data_next = {7'b0, spare_cnt_next, spare_next, time_avail_next,
                         exhausted_next, over, slip, run};
    end

    // Output register: load on evaluate, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            loop_rate_reg   <= LOOP_RATE_RST;
            pass_budget_reg <= PASS_BUDGET_RST;
            time_avail_reg  <= PASS_BUDGET_RST;
            allowed_reg     <= '0;
            exhausted_reg   <= 1'b0;
            spare_reg       <= '0;
            spare_cnt_reg   <= '0;
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                last_run_tick_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            // Register writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LOOP_RATE:   loop_rate_reg   <= cfg_data;
                    REG_PASS_BUDGET: pass_budget_reg <= cfg_data;
                    default:         loop_rate_reg   <= loop_rate_reg;
                endcase
            end
            // Commit state on evaluate
            if (fire)
            begin
                time_avail_reg <= time_avail_next;
                allowed_reg    <= allowed_next;
                exhausted_reg  <= exhausted_next;
                spare_reg      <= spare_next;
                spare_cnt_reg  <= spare_cnt_next;
                if (stamp)
                begin
                    last_run_tick_reg[idx_reg] <= tick_reg;
                end
            end
        end
    end

    // Hold the accepted word and the pending result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func_t'(s_axis_tuser);
            idx_reg   <= s_axis_tdata[3:0];
            tick_reg  <= s_axis_tdata[35:4];
            max_reg   <= s_axis_tdata[67:52];
            taken_reg <= s_axis_tdata[99:68];
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> hw/rtl/brts_checker.sv
`include "budgeted_rate_task_scheduler_macros.svh"

module brts_checker
    import brts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // One item at a time: no word is taken right after another
    `BRTS_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A stalled result word keeps its contents
    `BRTS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // A task never runs in a pass whose budget is spent
    `BRTS_ASSERT_NOW(a_run_in_budget, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[3])

    // Run and overrun come from different functions
    `BRTS_ASSERT_NOW(a_run_not_over, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[2]))

endmodule

bind budgeted_rate_task_scheduler brts_checker u_brts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
